>>> hdl/waypoint_steering_controller_assert.svh
// Assertion macros for the waypoint steering controller.
`ifndef WAYPOINT_STEERING_CONTROLLER_ASSERT_SVH
`define WAYPOINT_STEERING_CONTROLLER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define WSC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define WSC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WSC_ASSERT(label, clk, rst_n, prop, msg)
`define WSC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

>>> hdl/wsc_pkg.sv
// ----------------------------------------------------------------------------
// Waypoint steering controller package
// Types, constants and the arctangent table shared by the controller.
// ----------------------------------------------------------------------------
package wsc_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int POS_WIDTH_DEF    = 16;
  localparam int TAB_LEN          = 24;

  // Fixed-point angle constants, Q3.12 and Q7.16.
  localparam logic signed [15:0] PI_Q12      = 16'sd12868;
  localparam logic signed [15:0] HALF_PI_Q12 = 16'sd6434;
  localparam logic signed [23:0] HALF_PI_Q16 = 24'sd102944;
  localparam logic [15:0]        INV_GAIN_Q16 = 16'd39797;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_GOAL_X    = 2'd0;
  localparam logic [1:0] REG_GOAL_Y    = 2'd1;
  localparam logic [1:0] REG_FIRST_LEG = 2'd2;
  localparam logic [1:0] REG_TOL       = 2'd3;

  typedef struct packed {
    logic               action;
    logic signed [15:0] pose_x;
    logic signed [15:0] pose_y;
    logic signed [15:0] pose_heading;
  } wsc_in_t;

  typedef struct packed {
    logic signed [17:0] linear_cmd;
    logic signed [15:0] angular_cmd;
    logic               arrived;
  } wsc_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRE,
    ST_ITER,
    ST_MAG,
    ST_FINISH,
    ST_OUT
  } wsc_state_e;

  // Arctangent of 2^-i in units of 2^-16 rad.
  function automatic logic [15:0] atan_q16(input logic [4:0] i);
    logic [15:0] r;
    case (i)
      5'd0:  r = 16'd51472;
      5'd1:  r = 16'd30386;
      5'd2:  r = 16'd16055;
      5'd3:  r = 16'd8150;
      5'd4:  r = 16'd4091;
      5'd5:  r = 16'd2047;
      5'd6:  r = 16'd1024;
      5'd7:  r = 16'd512;
      5'd8:  r = 16'd256;
      5'd9:  r = 16'd128;
      5'd10: r = 16'd64;
      5'd11: r = 16'd32;
      5'd12: r = 16'd16;
      5'd13: r = 16'd8;
      5'd14: r = 16'd4;
      5'd15: r = 16'd2;
      5'd16: r = 16'd1;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/waypoint_steering_controller.sv
// ----------------------------------------------------------------------------
// Waypoint steering controller
// Go-to-goal proportional steering with a sequenced CORDIC vectoring unit.
// ----------------------------------------------------------------------------
// Usage:
//   Input transactions carry an action bit and a pose. A pose sample is
//   stored; during an open leg it also runs one CORDIC vectoring pass that
//   gives distance and bearing to the goal, and at most one command
//   transaction follows. A start transaction latches the offset and heading
//   of the stored pose, runs the same pass for the goal bearing, and opens
//   a leg without a result.
//   One shared add/subtract-shift datapath does one CORDIC round a cycle.
//   After acceptance the sequencer runs the quadrant fold (ST_PRE),
//   CORDIC_STEPS rounds (ST_ITER), the gain multiply (ST_MAG) and the
//   command (ST_FINISH), then registers the result. in_ready_o stays low
//   until the result has been taken or the item finished silently, so no new
//   item is taken before the last is through; a pose outside a leg leaves
//   the block idle.
//   While the receiver stalls, the result holds in the output register and
//   no new item is taken.
//   Reset clears the stored pose, the leg state and the registers to their
//   defaults (goal 0,0, first leg set, tolerance 20). Configuration must be written
//   over the APB port while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module waypoint_steering_controller #(
  parameter int CORDIC_STEPS = wsc_pkg::CORDIC_STEPS_DEF,
  parameter int POS_WIDTH    = wsc_pkg::POS_WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  wsc_pkg::wsc_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output wsc_pkg::wsc_out_t out_data_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import wsc_pkg::*;

  `include "waypoint_steering_controller_assert.svh"

  localparam int DW = POS_WIDTH + 1;        // offset width
  localparam int CW = DW + 13;              // CORDIC x/y width with guard and growth
  localparam int SW = $clog2(CORDIC_STEPS + 1);

  // Configuration registers.
  logic signed [POS_WIDTH-1:0] goal_x_q, goal_y_q;
  logic                        first_leg_q;
  logic [14:0]                 tol_q;
  logic                        wr_en;
  logic [1:0]                  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_x_q    <= '0;
      goal_y_q    <= '0;
      first_leg_q <= 1'b1;
      tol_q       <= 15'd20;
    end else if (wr_en) begin
      case (reg_idx)
        REG_GOAL_X:    goal_x_q    <= pwdata[POS_WIDTH-1:0];
        REG_GOAL_Y:    goal_y_q    <= pwdata[POS_WIDTH-1:0];
        REG_FIRST_LEG: first_leg_q <= pwdata[0];
        REG_TOL:       tol_q       <= pwdata[14:0];
        default:       ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (reg_idx)
      REG_GOAL_X:    prdata = 32'(goal_x_q);
      REG_GOAL_Y:    prdata = 32'(goal_y_q);
      REG_FIRST_LEG: prdata = {31'd0, first_leg_q};
      REG_TOL:       prdata = {17'd0, tol_q};
      default:       prdata = '0;
    endcase
  end

  // Block state.
  wsc_state_e state_q, state_d;
  logic signed [POS_WIDTH-1:0] stored_x_q, stored_y_q;
  logic signed [15:0]          stored_h_q, ref_h_q, bearing_q, head_q;
  logic signed [DW-1:0]        ref_dx_q, ref_dy_q;
  logic                        leg_q, start_q;
  logic signed [CW-1:0]        cx_q, cy_q;
  logic signed [24:0]          cz_q;
  logic [SW-1:0]               step_q;
  logic [CW+15:0]              prod_q;
  wsc_out_t                    out_q;
  logic                        out_vld_q;

  logic in_acc, out_acc;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i & in_ready_o;
  assign out_acc     = out_valid_o & out_ready_i;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // Heading wrapped once into [-pi, pi].
  logic signed [16:0] h_in, h_wr;
  always_comb begin
    h_in = 17'(in_data_i.pose_heading);
    if (h_in > 17'(PI_Q12)) h_wr = h_in - 17'sd25736;
    else if (h_in < -17'(PI_Q12)) h_wr = h_in + 17'sd25736;
    else h_wr = h_in;
  end

  // Next-state logic.
  logic cordic_done, mag_lt, mag_eq, emit;
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data_i.action) state_d = ST_PRE;
          else if (leg_q) state_d = ST_PRE;
        end
      end
      ST_PRE:    state_d = ST_ITER;
      ST_ITER:   if (cordic_done) state_d = ST_MAG;
      ST_MAG:    state_d = ST_FINISH;
      ST_FINISH: state_d = (emit && !start_q) ? ST_OUT : ST_IDLE;
      ST_OUT:    if (out_acc) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  // Offset sources for the vectoring pass.
  logic signed [DW-1:0] sdx, sdy, vx, vy;
  assign sdx = DW'(goal_x_q) - DW'(stored_x_q);
  assign sdy = DW'(goal_y_q) - DW'(stored_y_q);
  always_comb begin
    if (start_q) begin
      vx = ref_dx_q;
      vy = ref_dy_q[DW-1] ? -ref_dy_q : ref_dy_q;
    end else begin
      vx = sdx;
      vy = sdy;
    end
  end

  // Shared CORDIC rotation unit: one micro-rotation per cycle.
  logic signed [CW-1:0] xs, ys, gx, gy;
  logic signed [24:0]   at;
  assign xs = cx_q >>> step_q;
  assign ys = cy_q >>> step_q;
  assign at = 25'(atan_q16(5'(step_q)));
  assign gx = CW'(vx) <<< 10;
  assign gy = CW'(vy) <<< 10;
  assign cordic_done = (32'(step_q) == CORDIC_STEPS - 1);

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_PRE: begin
        step_q <= '0;
        if (gx < 0) begin
          if (gy >= 0) begin
            cx_q <= gy; cy_q <= -gx; cz_q <= 25'(HALF_PI_Q16);
          end else begin
            cx_q <= -gy; cy_q <= gx; cz_q <= -25'(HALF_PI_Q16);
          end
        end else begin
          cx_q <= gx; cy_q <= gy; cz_q <= '0;
        end
      end
      ST_ITER: begin
        step_q <= step_q + 1'b1;
        if (cy_q >= 0) begin
          cx_q <= cx_q + ys; cy_q <= cy_q - xs; cz_q <= cz_q + at;
        end else begin
          cx_q <= cx_q - ys; cy_q <= cy_q + xs; cz_q <= cz_q - at;
        end
      end
      ST_MAG: begin
        prod_q <= (cx_q < 0) ? '0 : (CW+16)'(cx_q) * (CW+16)'(INV_GAIN_Q16);
      end
      default: ;
    endcase
  end

  // Distance, angle and heading error.
  logic [CW+15:0]       dsum;
  logic [CW-11:0]       dist_mag;
  logic signed [24:0]   zr;
  logic signed [15:0]   phi, abs_a;
  logic signed [17:0]   e0, e;
  logic signed [17:0]   dal, sa;
  assign dsum     = prod_q + (CW+16)'(33554432);
  assign dist_mag = dsum[CW+15:26] ;
  assign zr    = (cz_q + 25'sd8) >>> 4;
  assign phi   = zr[15:0];
  assign abs_a = phi[15] ? -phi : phi;
  assign mag_lt = 32'(dist_mag) < 32'(tol_q);
  assign mag_eq = 32'(dist_mag) == 32'(tol_q);
  always_comb begin
    e0 = 18'(phi) - 18'(head_q);
    if (e0 > 18'(PI_Q12)) e = e0 - 18'sd25736;
    else if (e0 < -18'(PI_Q12)) e = e0 + 18'sd25736;
    else e = e0;
    dal = e[17] ? -e : e;
    if (dal > 18'(PI_Q12)) dal = 18'(PI_Q12);
    if (dal <= 18'(HALF_PI_Q12)) sa = e;
    else sa = e[17] ? -(18'(PI_Q12) - dal) : 18'(PI_Q12) - dal;
  end

  // Branch tree of later legs.
  logic        tv, tp, t2;
  logic signed [1:0] sl, sg;
  logic        rv;
  logic signed [15:0] t, tg;
  always_comb begin
    t = ref_h_q; tg = bearing_q;
    tv = 1'b1; t2 = 1'b0; sl = 2'sd1; sg = -2'sd1; rv = 1'b0;
    tp = ref_dy_q > 0;
    if (t > 0 && t != PI_Q12) begin
      if (ref_dy_q > 0) begin
        sl = 2'sd1; sg = (tg <= t) ? -2'sd1 : 2'sd1; rv = 1'b0;
      end else if (ref_dy_q < 0) begin
        sl = -2'sd1; sg = (PI_Q12 - tg <= t) ? -2'sd1 : 2'sd1; rv = 1'b1;
      end else if (ref_dx_q > 0) begin
        if (t > HALF_PI_Q12) begin sl = -2'sd1; sg = 2'sd1; rv = 1'b1; end
        else begin sl = 2'sd1; sg = -2'sd1; rv = 1'b0; end
      end else begin
        if (t > HALF_PI_Q12) begin sl = 2'sd1; sg = 2'sd1; rv = 1'b0; end
        else begin sl = -2'sd1; sg = -2'sd1; rv = 1'b1; end
      end
    end else if (t < 0 && t != -PI_Q12) begin
      if (ref_dy_q > 0) begin
        sl = -2'sd1; sg = (-PI_Q12 + tg <= t) ? -2'sd1 : 2'sd1; rv = 1'b1;
      end else if (ref_dy_q < 0) begin
        sl = 2'sd1; sg = (-tg <= t) ? -2'sd1 : 2'sd1; rv = 1'b0;
      end else if (ref_dx_q > 0) begin
        if (t >= -HALF_PI_Q12) begin sl = 2'sd1; sg = 2'sd1; rv = 1'b0; end
        else begin sl = -2'sd1; sg = -2'sd1; rv = 1'b1; end
      end else begin
        if (t >= -HALF_PI_Q12) begin sl = -2'sd1; sg = 2'sd1; rv = 1'b1; end
        else begin sl = 2'sd1; sg = -2'sd1; rv = 1'b0; end
      end
    end else if (t != 0) begin
      if (tp) begin
        if (tg <= HALF_PI_Q12) begin sl = -2'sd1; sg = 2'sd1; rv = 1'b1; end
        else begin sl = 2'sd1; sg = -2'sd1; rv = 1'b0; end
      end else if (ref_dy_q < 0) begin
        if (tg <= HALF_PI_Q12) begin sl = -2'sd1; sg = -2'sd1; rv = 1'b1; end
        else begin sl = 2'sd1; sg = 2'sd1; rv = 1'b0; end
      end else if (ref_dx_q > 0) begin t2 = 1'b1; sl = -2'sd1; end
      else if (ref_dx_q < 0) begin t2 = 1'b1; sl = 2'sd1; end
      else tv = 1'b0;
    end else begin
      if (tp) begin
        if (tg <= HALF_PI_Q12) begin sl = -2'sd1; sg = 2'sd1; rv = 1'b1; end
        else begin sl = 2'sd1; sg = -2'sd1; rv = 1'b0; end
      end else if (ref_dy_q < 0) begin
        if (tg <= HALF_PI_Q12) begin sl = 2'sd1; sg = -2'sd1; rv = 1'b0; end
        else begin sl = -2'sd1; sg = 2'sd1; rv = 1'b1; end
      end else if (ref_dx_q > 0) begin t2 = 1'b1; sl = 2'sd1; end
      else if (ref_dx_q < 0) begin t2 = 1'b1; sl = -2'sd1; end
      else tv = 1'b0;
    end
  end

  // Command arithmetic and saturation.
  logic signed [CW+2:0] dd, lin_w, lin_m;
  logic signed [20:0]   base, mm, ang_w;
  logic signed [17:0]   lin_s;
  logic signed [15:0]   ang_s;
  always_comb begin
    dd    = (CW+3)'(dist_mag);
    base  = rv ? 21'(PI_Q12) - 21'(dal) : 21'(dal);
    mm    = (21'sd9 * base + 21'sd2) >>> 2;
    lin_m = ((CW+3)'(3) * dd + (CW+3)'(1)) >>> 1;
    if (first_leg_q) begin
      lin_w = dd;
      ang_w = 21'(sa) <<< 1;
    end else if (t2) begin
      lin_w = (sl < 0) ? -(dd <<< 1) : (dd <<< 1);
      ang_w = '0;
    end else begin
      lin_w = (sl < 0) ? -lin_m : lin_m;
      ang_w = (sg < 0) ? -mm : mm;
    end
    if (lin_w > (CW+3)'(131071)) lin_s = 18'sd131071;
    else if (lin_w < -(CW+3)'(131072)) lin_s = -18'sd131072;
    else lin_s = lin_w[17:0];
    if (ang_w > 21'sd32767) ang_s = 16'sd32767;
    else if (ang_w < -21'sd32768) ang_s = -16'sd32768;
    else ang_s = ang_w[15:0];
    emit = mag_lt || (!mag_eq && (first_leg_q || tv));
  end

  // Pose, leg and start bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored_x_q <= '0; stored_y_q <= '0; stored_h_q <= '0;
      ref_dx_q <= '0; ref_dy_q <= '0; ref_h_q <= '0; bearing_q <= '0;
      leg_q <= 1'b0; start_q <= 1'b0; head_q <= '0;
      out_vld_q <= 1'b0; out_q <= '0;
    end else begin
      if (in_acc) begin
        start_q <= in_data_i.action;
        if (in_data_i.action) begin
          ref_dx_q <= sdx;
          ref_dy_q <= sdy;
          ref_h_q  <= stored_h_q;
          leg_q    <= 1'b1;
        end else begin
          stored_x_q <= POS_WIDTH'(in_data_i.pose_x);
          stored_y_q <= POS_WIDTH'(in_data_i.pose_y);
          stored_h_q <= h_wr[15:0];
          head_q     <= h_wr[15:0];
        end
      end
      if (state_q == ST_FINISH) begin
        if (start_q) begin
          if (ref_dx_q == 0 && ref_dy_q == 0) bearing_q <= '0;
          else bearing_q <= (abs_a > PI_Q12) ? PI_Q12 : abs_a;
        end else if (emit) begin
          out_vld_q <= 1'b1;
          if (mag_lt) begin
            leg_q <= 1'b0;
            out_q <= '{linear_cmd: '0, angular_cmd: '0, arrived: 1'b1};
          end else begin
            out_q <= '{linear_cmd: lin_s, angular_cmd: ang_s, arrived: 1'b0};
          end
        end
      end
      if (out_acc) out_vld_q <= 1'b0;
    end
  end

  `WSC_ASSERT(a_no_accept_busy, clk_i, rst_ni, in_acc |-> (state_q == ST_IDLE && !out_vld_q), "accept while busy")
  `WSC_ASSERT(a_out_only_in_out, clk_i, rst_ni, out_vld_q |-> (state_q == ST_OUT), "result outside output state")
  `WSC_ASSERT(a_arrive_closes, clk_i, rst_ni, (out_acc && out_q.arrived) |-> !leg_q, "arrival left leg open")
  `WSC_ASSERT(a_arrive_zero, clk_i, rst_ni, (out_vld_q && out_q.arrived) |-> (out_q.linear_cmd == 0 && out_q.angular_cmd == 0), "arrival with nonzero command")

endmodule
